FILE: rtl/core/ntc_trimmed_mean_temperature_unit_macros.svh
// ----------------------------------------------------------------------------
// NTC trimmed mean temperature unit assertion macros
// Shared concurrent assertion forms clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NTC_TRIMMED_MEAN_TEMPERATURE_UNIT_MACROS_SVH
`define NTC_TRIMMED_MEAN_TEMPERATURE_UNIT_MACROS_SVH

// Same-cycle implication.
`define NTC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define NTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/ntc_tm_pkg.sv
// ----------------------------------------------------------------------------
// NTC trimmed mean package
// Shared types and constants of the NTC trimmed mean temperature unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ntc_tm_pkg;

  localparam logic [2:0] REG_FIXED_R = 3'd0;
  localparam logic [2:0] REG_REF_R   = 3'd1;
  localparam logic [2:0] REG_BETA    = 3'd2;
  localparam logic [2:0] REG_TREF    = 3'd3;
  localparam logic [2:0] REG_FS      = 3'd4;

  localparam logic [19:0] RESET_FIXED_R = 20'd10000;
  localparam logic [19:0] RESET_REF_R   = 20'd10000;
  localparam logic [15:0] RESET_BETA    = 16'd3950;
  localparam logic [15:0] RESET_TREF    = 16'd29815;
  localparam logic [12:0] RESET_FS      = 13'd4095;

  localparam logic [31:0]        LN2_Q32        = 32'd2977044472;
  localparam logic [16:0]        KELVIN_OFFSET  = 17'd27315;
  localparam logic [16:0]        Q_LIMIT        = 17'd60082;
  localparam logic signed [15:0] INVALID_TEMP   = -16'sd9900;
  localparam logic signed [15:0] TEMP_MAX       = 16'sd32767;

  typedef struct packed {
    logic [19:0] fixed_r;
    logic [19:0] ref_r;
    logic [15:0] beta;
    logic [15:0] tref;
    logic [12:0] full_scale;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/ntc_trimmed_mean_temperature_unit.sv
// ----------------------------------------------------------------------------
// NTC trimmed mean temperature unit
// Averages the middle samples of each group of ADC codes and converts the
// average into a temperature with the beta equation.
// ----------------------------------------------------------------------------
// Samples enter on in_valid / in_stall / sample_code; a transfer takes place
// when in_valid is high and in_stall is low. The front part takes one sample
// per cycle while the queue is not full and queues a trimmed sum on the last
// sample of each group. One result per group leaves on out_valid / out_stall
// with temp_centi_celsius, in_range and average_code, held while out_stall is
// high. The back part takes the queued sum, forms the average with one
// reciprocal multiply, runs four log2 conversions (a load, then squaring
// rounds for 24 fraction bits each), steps through ST_LNMUL, ST_LNSGN,
// ST_TLMUL, ST_NUMMUL, ST_DENCHK and ST_QCHK, forms a 17-bit serial quotient
// and loads the output register. An out-of-range average goes from ST_DIV
// straight to ST_DONE. The back part sets the sustained rate; a two-entry
// queue lets the front run ahead by two groups while it works on one.
// While out_stall holds a result the back part waits, the queue fills and
// in_stall rises. Configuration writes use cfg_valid / cfg_ready (always
// ready) with cfg_index and cfg_data; the user must make them only while the
// unit is idle, which the unit itself does not enforce. Synchronous reset
// restores the default registers, empties the queue and starts a new group.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_trimmed_mean_temperature_unit #(
  parameter int GROUP_SIZE = 8,
  parameter int ADC_BITS   = 12
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [19:0]  cfg_data,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [11:0]  sample_code,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic signed [15:0] temp_centi_celsius,
  output logic              in_range,
  output logic [11:0]       average_code
);
  import ntc_tm_pkg::*;

  localparam int SW = ADC_BITS + $clog2(GROUP_SIZE);

  cfg_t          cfg;
  q_status_t     q_status;
  logic          push;
  logic [SW-1:0] push_data;
  logic          pop;
  logic [SW-1:0] pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fixed_r    <= RESET_FIXED_R;
      cfg.ref_r      <= RESET_REF_R;
      cfg.beta       <= RESET_BETA;
      cfg.tref       <= RESET_TREF;
      cfg.full_scale <= RESET_FS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FIXED_R: cfg.fixed_r    <= cfg_data;
        REG_REF_R:   cfg.ref_r      <= cfg_data;
        REG_BETA:    cfg.beta       <= cfg_data[15:0];
        REG_TREF:    cfg.tref       <= cfg_data[15:0];
        REG_FS:      cfg.full_scale <= cfg_data[12:0];
        default:     cfg.fixed_r    <= cfg.fixed_r;
      endcase
    end
  end

  ntc_tm_front #(
    .GROUP_SIZE(GROUP_SIZE),
    .ADC_BITS  (ADC_BITS),
    .SW        (SW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_code(sample_code),
    .q_status   (q_status),
    .push       (push),
    .push_data  (push_data)
  );

  ntc_tm_queue #(
    .WIDTH(SW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .status   (q_status)
  );

  ntc_tm_back #(
    .GROUP_SIZE(GROUP_SIZE),
    .ADC_BITS  (ADC_BITS),
    .SW        (SW)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .q_status          (q_status),
    .q_data            (pop_data),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .temp_centi_celsius(temp_centi_celsius),
    .in_range          (in_range),
    .average_code      (average_code)
  );

endmodule

`default_nettype wire

FILE: rtl/core/ntc_tm_queue.sv
// ----------------------------------------------------------------------------
// NTC trimmed mean job queue
// Two-entry queue of trimmed group sums between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_tm_queue #(
  parameter int WIDTH = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire logic [WIDTH-1:0]      push_data,
  input  wire logic                  pop,
  output logic [WIDTH-1:0]           pop_data,
  output ntc_tm_pkg::q_status_t      status
);
  import ntc_tm_pkg::*;

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ntc_tm_front.sv
// ----------------------------------------------------------------------------
// NTC trimmed mean front part
// Accepts samples, tracks the group minimum, maximum and sum, and queues the
// trimmed sum of each finished group.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_tm_front #(
  parameter int GROUP_SIZE = 8,
  parameter int ADC_BITS   = 12,
  parameter int SW         = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [11:0]           sample_code,
  input  wire ntc_tm_pkg::q_status_t q_status,
  output logic                       push,
  output logic [SW-1:0]              push_data
);
  import ntc_tm_pkg::*;

  localparam int CNTW = $clog2(GROUP_SIZE);

  logic [CNTW-1:0]     sample_count;
  logic [ADC_BITS-1:0] running_min;
  logic [ADC_BITS-1:0] running_max;
  logic [SW-1:0]       running_sum;

  logic [15:0]         samp_wide;
  logic [ADC_BITS-1:0] v;
  logic [ADC_BITS-1:0] min_next;
  logic [ADC_BITS-1:0] max_next;
  logic [SW-1:0]       sum_next;
  logic                accept;
  logic                last;

  assign samp_wide = {4'b0, sample_code};
  assign v         = samp_wide[ADC_BITS-1:0];
  assign in_stall  = q_status.full;
  assign accept    = in_valid && !in_stall;
  assign last      = (sample_count == CNTW'(GROUP_SIZE - 1));
  assign min_next  = (v < running_min) ? v : running_min;
  assign max_next  = (v > running_max) ? v : running_max;
  assign sum_next  = running_sum + SW'(v);
  assign push      = accept && last;
  assign push_data = sum_next - SW'(min_next) - SW'(max_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      running_min  <= '1;
      running_max  <= '0;
      running_sum  <= '0;
    end else if (accept) begin
      if (last) begin
        sample_count <= '0;
        running_min  <= '1;
        running_max  <= '0;
        running_sum  <= '0;
      end else begin
        sample_count <= sample_count + CNTW'(1);
        running_min  <= min_next;
        running_max  <= max_next;
        running_sum  <= sum_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ntc_tm_back.sv
// ----------------------------------------------------------------------------
// NTC trimmed mean back part
// Divides the trimmed sum into the average code, takes four iterative log2
// values, and runs the beta equation with a serial quotient into the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ntc_trimmed_mean_temperature_unit_macros.svh"

module ntc_tm_back #(
  parameter int GROUP_SIZE = 8,
  parameter int ADC_BITS   = 12,
  parameter int SW         = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ntc_tm_pkg::cfg_t      cfg,
  input  wire ntc_tm_pkg::q_status_t q_status,
  input  wire logic [SW-1:0]         q_data,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [15:0]         temp_centi_celsius,
  output logic                       in_range,
  output logic [11:0]                average_code
);
  import ntc_tm_pkg::*;

  localparam int DIVISOR = GROUP_SIZE - 2;
  localparam int RSH     = SW + $clog2(DIVISOR);
  localparam int RW      = RSH + 1;
  localparam int PW      = SW + RW;
  localparam logic [RW-1:0] RECIP =
    RW'(((longint'(1) << RSH) + longint'(DIVISOR) - 1) / longint'(DIVISOR));

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DIV    = 4'd1;
  localparam logic [3:0] ST_LOAD   = 4'd2;
  localparam logic [3:0] ST_LOG    = 4'd3;
  localparam logic [3:0] ST_LNMUL  = 4'd4;
  localparam logic [3:0] ST_LNSGN  = 4'd5;
  localparam logic [3:0] ST_TLMUL  = 4'd6;
  localparam logic [3:0] ST_NUMMUL = 4'd7;
  localparam logic [3:0] ST_DENCHK = 4'd8;
  localparam logic [3:0] ST_QCHK   = 4'd9;
  localparam logic [3:0] ST_QDIV   = 4'd10;
  localparam logic [3:0] ST_DONE   = 4'd11;

  logic [3:0]          state;
  logic [SW-1:0]       divd;
  logic [ADC_BITS-1:0] avg;
  logic [1:0]          log_idx;
  logic [4:0]          log_n;
  logic [30:0]         m;
  logic [23:0]         frac;
  logic [4:0]          rcnt;
  logic signed [31:0]  acc;
  logic                neg;
  logic [62:0]         lnprod;
  logic signed [23:0]  ln;
  logic signed [40:0]  tl;
  logic [31:0]         tb;
  logic signed [41:0]  den;
  logic [56:0]         dvd;
  logic [41:0]         dsor;
  logic [56:0]         qrem;
  logic [57:0]         dsh;
  logic [16:0]         q;
  logic [4:0]          qcnt;
  logic signed [15:0]  res_temp;
  logic                res_ok;

  logic [PW-1:0]       avg_prod;
  logic [SW-1:0]       quot;
  logic [16:0]         avg17;
  logic [16:0]         fs17;
  logic [16:0]         diff17;
  logic                ok;
  logic [19:0]         rf_eff;
  logic [19:0]         rr_eff;
  logic [15:0]         b_eff;
  logic [19:0]         log_x;
  logic [4:0]          top_n;
  logic [61:0]         prod;
  logic [31:0]         p;
  logic [23:0]         frac_new;
  logic [28:0]         log_val;
  logic signed [31:0]  acc_new;
  logic [31:0]         acc_neg;
  logic [30:0]         mag;
  logic [22:0]         b100;
  logic [38:0]         num39;
  logic                ge;
  logic [16:0]         q_new;
  logic                out_free;
  logic                load_out;

  assign avg_prod = PW'(divd) * PW'(RECIP);
  assign quot     = avg_prod[RSH+SW-1:RSH];
  assign avg17    = 17'(quot[ADC_BITS-1:0]);
  assign fs17     = 17'(cfg.full_scale);
  assign diff17   = fs17 - 17'(avg);
  assign ok       = (avg17 != 17'd0) && (avg17 < fs17);
  assign rf_eff   = (cfg.fixed_r == 20'd0) ? 20'd1 : cfg.fixed_r;
  assign rr_eff   = (cfg.ref_r == 20'd0) ? 20'd1 : cfg.ref_r;
  assign b_eff    = (cfg.beta == 16'd0) ? 16'd1 : cfg.beta;
  assign prod     = m * m;
  assign p        = prod[61:30];
  assign frac_new = {frac[22:0], p[31]};
  assign log_val  = {log_n, frac_new};
  assign acc_new  = log_idx[1] ? (acc - $signed({3'b0, log_val}))
                               : (acc + $signed({3'b0, log_val}));
  assign acc_neg  = -acc;
  assign mag      = acc[31] ? acc_neg[30:0] : acc[30:0];
  assign b100     = 23'(b_eff * 23'd100);
  assign num39    = 39'(tb) * 39'd100;
  assign ge       = (58'(qrem) >= dsh);
  assign q_new    = {q[15:0], ge};
  assign out_free = !out_valid || !out_stall;
  assign load_out = (state == ST_DONE) && out_free;
  assign pop      = (state == ST_IDLE) && !q_status.empty;

  always_comb begin
    case (log_idx)
      2'd0:    log_x = rf_eff;
      2'd1:    log_x = 20'(avg);
      2'd2:    log_x = 20'(diff17[12:0]);
      default: log_x = rr_eff;
    endcase
  end

  always_comb begin
    top_n = 5'd0;
    for (int i = 0; i < 20; i++) begin
      if (log_x[i]) begin
        top_n = 5'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_status.empty) begin
            divd  <= q_data;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          avg     <= quot[ADC_BITS-1:0];
          res_ok  <= ok;
          log_idx <= 2'd0;
          acc     <= '0;
          if (ok) begin
            state <= ST_LOAD;
          end else begin
            res_temp <= INVALID_TEMP;
            state    <= ST_DONE;
          end
        end
        ST_LOAD: begin
          m     <= 31'({11'b0, log_x} << (5'd30 - top_n));
          log_n <= top_n;
          frac  <= '0;
          rcnt  <= 5'd23;
          state <= ST_LOG;
        end
        ST_LOG: begin
          m    <= p[31] ? p[31:1] : p[30:0];
          frac <= frac_new;
          if (rcnt == 5'd0) begin
            acc     <= acc_new;
            log_idx <= log_idx + 2'd1;
            state   <= (log_idx == 2'd3) ? ST_LNMUL : ST_LOAD;
          end else begin
            rcnt <= rcnt - 5'd1;
          end
        end
        ST_LNMUL: begin
          lnprod <= mag * LN2_Q32;
          neg    <= acc[31];
          state  <= ST_LNSGN;
        end
        ST_LNSGN: begin
          ln    <= neg ? -$signed({1'b0, lnprod[62:40]}) : $signed({1'b0, lnprod[62:40]});
          state <= ST_TLMUL;
        end
        ST_TLMUL: begin
          tl    <= $signed({1'b0, cfg.tref}) * ln;
          state <= ST_NUMMUL;
        end
        ST_NUMMUL: begin
          tb    <= cfg.tref * b_eff;
          den   <= $signed({3'b0, b100, 16'b0}) + 42'(tl);
          state <= ST_DENCHK;
        end
        ST_DENCHK: begin
          if (den[41] || den == 42'sd0) begin
            res_temp <= TEMP_MAX;
            state    <= ST_DONE;
          end else begin
            dvd   <= 57'({num39, 17'b0}) + 57'(den[40:0]);
            dsor  <= {den[40:0], 1'b0};
            state <= ST_QCHK;
          end
        end
        ST_QCHK: begin
          if (59'(dvd) >= {dsor, 17'b0}) begin
            res_temp <= TEMP_MAX;
            state    <= ST_DONE;
          end else begin
            qrem  <= dvd;
            dsh   <= {dsor, 16'b0};
            q     <= '0;
            qcnt  <= 5'd16;
            state <= ST_QDIV;
          end
        end
        ST_QDIV: begin
          if (ge) begin
            qrem <= qrem - dsh[56:0];
          end
          q   <= q_new;
          dsh <= dsh >> 1;
          if (qcnt == 5'd0) begin
            res_temp <= (q_new > Q_LIMIT) ? TEMP_MAX : $signed(16'(q_new - KELVIN_OFFSET));
            state    <= ST_DONE;
          end else begin
            qcnt <= qcnt - 5'd1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      temp_centi_celsius <= res_temp;
      in_range           <= res_ok;
      average_code       <= 12'(17'(avg));
    end
  end

  `NTC_ASSERT_IMPL(a_pop_nonempty, pop, !q_status.empty, "pop from an empty queue")
  `NTC_ASSERT_IMPL(a_load_free, load_out, !out_valid || !out_stall, "result overwrote a held result")
  `NTC_ASSERT_IMPL(a_invalid_temp, out_valid && !in_range, temp_centi_celsius == INVALID_TEMP, "out of range result without the invalid temperature")
  `NTC_ASSERT_NEXT(a_start_div, state == ST_IDLE && !q_status.empty, state == ST_DIV, "queued group not started")

endmodule

`default_nettype wire
